/* hw/rtl/pcstp_pkg.sv */
// Package for the PC-indexed stride prefetcher: table geometry, field widths,
// the table entry layout and the write request that travels to the table.
// No dependencies.
package pcstp_pkg;

  // Table depth; must be a power of two so the PC low bits select the entry.
  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int PAGE_SHIFT    = 12;

  localparam int ADDR_W   = 64;
  localparam int PC_W     = 64;
  localparam int PAGE_W   = 52;
  localparam int STRIDE_W = PAGE_W + 1;  // top bit flags an unknown stride
  localparam int CONF_W   = 8;

  localparam logic [CONF_W-1:0]   CONF_MAX        = '1;
  localparam logic [CONF_W-1:0]   THRESHOLD_RESET = CONF_W'(2);
  localparam logic [STRIDE_W-1:0] STRIDE_UNKNOWN  = '1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [PAGE_W-1:0] page_t;

  typedef struct packed {
    logic [PC_W-1:0]     tag;
    page_t               last_page;
    logic [STRIDE_W-1:0] stride;
    logic [CONF_W-1:0]   conf;
  } entry_t;

  typedef struct packed {
    logic   en;
    idx_t   idx;
    entry_t data;
  } tbl_wr_t;

endpackage

/* hw/rtl/pcstp_if.sv */
// Channel interfaces of the stride prefetcher: access requests in,
// prefetch page numbers out. Depends on pcstp_pkg.
interface pcstp_req_if import pcstp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] access_address;
  logic [PC_W-1:0]   program_counter;

  modport source (output valid, access_address, program_counter, input ready);
  modport sink   (input valid, access_address, program_counter, output ready);
endinterface

interface pcstp_pf_if import pcstp_pkg::*; ();
  logic  valid;
  logic  ready;
  page_t prefetch_page;

  modport source (output valid, prefetch_page, input ready);
  modport sink   (input valid, prefetch_page, output ready);
endinterface

/* hw/rtl/pc_stride_tlb_prefetcher.sv */
// Top level of the PC-indexed stride page prefetcher.
// Uses pcstp_pkg, pcstp_if, pcstp_table and pcstp_update.
//
// Usage:
//   in_chan  (sink)   : one request per access: access_address, program_counter.
//   out_chan (source) : zero or one prefetch_page per request, in request order.
//   cfg_we/cfg_wdata  : write confidence_threshold (reset value 2); write only
//                       while no request is in flight.
// Timing:
//   The edge that accepts a request issues the table read from idle; in the
//   look-up state the entry is updated and written back and the output
//   register is loaded, unless a stall holds the update there. A new request is
//   taken only once that read-modify-write of the table entry is done and the
//   block is back in idle.
// Reset:
//   rst_n is synchronous, active low. After reset a clearing pass zeroes all
//   TABLE_ENTRIES (1024) entries, one entry a cycle; in_chan.ready stays
//   low during the pass. Configuration writes are taken as ever.
// Stall:
//   The output register holds its prefetch until taken. A new request is still
//   accepted; only when it wants to emit while the output is full does its
//   update wait, and write-back and the next request wait with it.
module pc_stride_tlb_prefetcher import pcstp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  pcstp_req_if.sink         in_chan,
  pcstp_pf_if.source        out_chan,
  input  logic              cfg_we,
  input  logic [CONF_W-1:0] cfg_wdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic              state_r, state_nxt;
  logic [PC_W-1:0]   pc_r;
  page_t             page_r;
  logic [CONF_W-1:0] thr_r;
  logic              out_valid_r, out_valid_nxt;
  page_t             out_page_r;

  logic    clr_busy;
  logic    accept;
  logic    lk_go;
  entry_t  rd_data;
  entry_t  upd_entry;
  logic    upd_emit;
  page_t   upd_page;
  tbl_wr_t wr;

  // Take a request only in idle and after the clearing pass.
  assign in_chan.ready = (state_r == ST_IDLE) && !clr_busy;
  assign accept        = in_chan.valid && in_chan.ready;

  // Proceed with the update unless it emits into a full, stalled output.
  assign lk_go = !upd_emit || !out_valid_r || out_chan.ready;

  pcstp_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_idx   (in_chan.program_counter[IDX_W-1:0]),
    .rd_data  (rd_data),
    .wr       (wr),
    .clr_busy (clr_busy)
  );

  pcstp_update u_update (
    .cur       (rd_data),
    .pc        (pc_r),
    .page      (page_r),
    .threshold (thr_r),
    .nxt       (upd_entry),
    .emit      (upd_emit),
    .pf_page   (upd_page)
  );

  always_comb begin
    wr.en   = (state_r == ST_LOOK) && lk_go;
    wr.idx  = pc_r[IDX_W-1:0];
    wr.data = upd_entry;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        if (lk_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) out_valid_nxt = 1'b0;
    if (wr.en && upd_emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      thr_r       <= THRESHOLD_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) thr_r <= cfg_wdata;
    end
  end

  // Hold the request payload for the update cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      pc_r   <= in_chan.program_counter;
      page_r <= PAGE_W'(in_chan.access_address >> PAGE_SHIFT);
    end
    if (wr.en && upd_emit) begin
      out_page_r <= upd_page;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.prefetch_page = out_page_r;

  // A new prefetch appears only right after an update cycle.
  a_pf_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_LOOK))
    else $error("prefetch raised without a table update");

  // No request enters while the table is being cleared.
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !accept)
    else $error("request accepted during clearing pass");

  // An update that proceeds frees the block for the next request.
  a_update_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK && lk_go) |=> (state_r == ST_IDLE))
    else $error("update did not return to idle");

  // A stalled update keeps its read data and does not write the table.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK && !lk_go) |=> (state_r == ST_LOOK) && $stable(rd_data))
    else $error("stalled update lost its entry");

endmodule

/* hw/rtl/pcstp_table.sv */
// Prediction table: one synchronous memory with a registered read port,
// a write port and a clearing pass after reset. Depends on pcstp_pkg.
module pcstp_table import pcstp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    rd_en,
  input  idx_t    rd_idx,
  output entry_t  rd_data,
  input  tbl_wr_t wr,
  output logic    clr_busy
);

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data_r;
  logic   clr_busy_r;
  idx_t   clr_idx_r;

  // Sweep every entry to zero after reset, one per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + IDX_W'(1);
      if (clr_idx_r == IDX_W'(TABLE_ENTRIES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

/* hw/rtl/pcstp_update.sv */
// Entry update: tag check, stride learn or check, saturating confidence,
// prefetch decision and target page. Depends on pcstp_pkg.
module pcstp_update import pcstp_pkg::*; (
  input  entry_t            cur,
  input  logic [PC_W-1:0]   pc,
  input  page_t             page,
  input  logic [CONF_W-1:0] threshold,
  output entry_t            nxt,
  output logic              emit,
  output page_t             pf_page
);

  logic                hit;
  logic                unknown;
  logic                bump;
  page_t               diff;
  logic [STRIDE_W-1:0] stride_new;
  logic [CONF_W-1:0]   conf_new;

  always_comb begin
    hit        = (cur.tag == pc);
    diff       = page - cur.last_page;
    unknown    = cur.stride[STRIDE_W-1];
    bump       = unknown || (cur.stride[PAGE_W-1:0] == diff);
    stride_new = unknown ? {1'b0, diff} : cur.stride;
    if (!bump) begin
      conf_new = '0;
    end else if (cur.conf == CONF_MAX) begin
      conf_new = CONF_MAX;
    end else begin
      conf_new = cur.conf + CONF_W'(1);
    end

    emit    = hit && (conf_new > threshold);
    pf_page = page + stride_new[PAGE_W-1:0];

    nxt.tag       = pc;
    nxt.last_page = page;
    if (hit) begin
      nxt.stride = stride_new;
      nxt.conf   = conf_new;
    end else begin
      // Refill: unknown stride, counter cleared.
      nxt.stride = STRIDE_UNKNOWN;
      nxt.conf   = '0;
    end
  end

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for pc_stride_tlb_prefetcher: access requests in, prefetch pages out.
// Depends on pcstp_pkg, the pcstp_req_if / pcstp_pf_if interfaces and the prefetcher RTL.
// A directed table runs first, then random request streams under several thresholds and stalls.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcstp_pkg::*;

  localparam int PARK_CYCLES   = 80;   // long output hold that backs the block up
  localparam int SETTLE_CYCLES = 8;    // a request with no prefetch retires well within this
  localparam int DRAIN_LIMIT   = 5000;

  // One row of the directed table. Where has_typed is set, the expected outcome is
  // written out in the row; otherwise the predictor supplies it.
  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [PC_W-1:0]   pc;
    bit                has_typed;
    bit                typed_emits;
    page_t             typed_page;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic              cfg_we;
  logic [CONF_W-1:0] cfg_wdata;

  pcstp_req_if req_if ();
  pcstp_pf_if  pf_if ();

  pc_stride_tlb_prefetcher uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (pf_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor copy of the stride table and the threshold register.
  logic [PC_W-1:0]     tbl_tag    [TABLE_ENTRIES];
  page_t               tbl_last   [TABLE_ENTRIES];
  logic [STRIDE_W-1:0] tbl_stride [TABLE_ENTRIES];
  logic [CONF_W-1:0]   tbl_conf   [TABLE_ENTRIES];
  logic [CONF_W-1:0]   conf_threshold;

  // Prefetch pages still owed by the block, oldest first.
  page_t pending_prefetch [$];
  int    mismatch_count;

  // Idling knobs; the rates change only between phases, park_req also midway.
  int send_gap_pct;
  int recv_stall_pct;
  bit park_req;

  // Access streams for the random part: one PC each, walking pages by a stride.
  logic [PC_W-1:0] slot_pc     [6];
  page_t           slot_page   [6];
  page_t           slot_stride [6];
  logic [PC_W-1:0] sat_pc;
  page_t           sat_page;
  page_t           sat_stride;

  dir_row_t dir_rows [16] = '{
    // PC zero hits the cleared entries: a known stride of zero, counter climbs
    '{64'h0000_0000_0000_0000, 64'h0, 1'b1, 1'b0, '0},
    '{64'h0000_0000_0000_0FFF, 64'h0, 1'b1, 1'b0, '0},
    '{64'h0000_0000_0000_0ABC, 64'h0, 1'b1, 1'b1, '0},
    // all-ones PC misses and refills; then learn a stride of minus one page
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, '0},
    '{64'hFFFF_FFFF_FFFF_E000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
    '{64'hFFFF_FFFF_FFFF_D000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
    '{64'hFFFF_FFFF_FFFF_C123, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
    // learned minus one is an ordinary stride: a jump clears the counter
    '{64'hFFFF_FFFF_FFFF_F000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
    // top pages with stride +1: the difference and the prefetch wrap past zero
    '{64'hFFFF_FFFF_FFFF_C000, 64'h8000_0000_0000_0005, 1'b1, 1'b0, '0},
    '{64'hFFFF_FFFF_FFFF_D000, 64'h8000_0000_0000_0005, 1'b0, 1'b0, '0},
    '{64'hFFFF_FFFF_FFFF_E000, 64'h8000_0000_0000_0005, 1'b0, 1'b0, '0},
    '{64'hFFFF_FFFF_FFFF_F000, 64'h8000_0000_0000_0005, 1'b1, 1'b1, '0},
    '{64'h0000_0000_0000_0FFF, 64'h8000_0000_0000_0005, 1'b0, 1'b0, '0},
    // another PC with the same low bits evicts the entry, and back again
    '{64'h1234_5678_9ABC_DEF0, 64'h0000_0000_0000_0405, 1'b1, 1'b0, '0},
    '{64'h0000_0000_0000_1000, 64'h8000_0000_0000_0005, 1'b1, 1'b0, '0},
    '{64'h0000_0000_0000_0000, 64'h0, 1'b1, 1'b1, '0}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Append one owed prefetch behind the others.
  function automatic void owe_prefetch(input page_t pg);
    pending_prefetch = {pending_prefetch, pg};
  endfunction

  // Table update for one accepted request. Returns 1 when a prefetch is due.
  function automatic bit stride_predict(input logic [ADDR_W-1:0] addr,
                                        input logic [PC_W-1:0] pc, output page_t pf);
    idx_t  i;
    page_t pg;
    page_t delta;
    bit    bump;
    i  = idx_t'(pc);
    pg = page_t'(addr >> PAGE_SHIFT);
    pf = '0;
    if (tbl_tag[i] != pc) begin
      // miss: refill with an unknown stride, nothing emitted
      tbl_tag[i]    = pc;
      tbl_last[i]   = pg;
      tbl_stride[i] = STRIDE_UNKNOWN;
      tbl_conf[i]   = '0;
      return 1'b0;
    end
    delta = pg - tbl_last[i];
    bump  = 1'b0;
    if (tbl_stride[i][STRIDE_W-1]) begin
      tbl_stride[i] = {1'b0, delta};
      bump = 1'b1;
    end else if (tbl_stride[i][PAGE_W-1:0] == delta) begin
      bump = 1'b1;
    end
    if (!bump) tbl_conf[i] = '0;
    else if (tbl_conf[i] != CONF_MAX) tbl_conf[i] = tbl_conf[i] + CONF_W'(1);
    tbl_last[i] = pg;
    if (tbl_conf[i] > conf_threshold) begin
      pf = pg + tbl_stride[i][PAGE_W-1:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic page_t pick_stride();
    case ($urandom_range(5))
      0: return '0;
      1: return page_t'(1);
      2: return '1;
      3: return page_t'($urandom_range(64));
      4: return -page_t'($urandom_range(64));
      default: return page_t'({$urandom, $urandom});
    endcase
  endfunction

  // Offer one request and hold it until the block takes it. Gaps go in first.
  task automatic send_access(input logic [ADDR_W-1:0] addr, input logic [PC_W-1:0] pc);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      @(negedge clk);
      req_if.valid = 1'b0;
    end
    @(negedge clk);
    req_if.valid           = 1'b1;
    req_if.access_address  = addr;
    req_if.program_counter = pc;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Send a request and record the prefetch the predictor expects for it.
  task automatic issue(input logic [ADDR_W-1:0] addr, input logic [PC_W-1:0] pc);
    page_t pf;
    send_access(addr, pc);
    if (stride_predict(addr, pc, pf)) owe_prefetch(pf);
  endtask

  // Drop valid and hold until every owed prefetch has come out.
  task automatic drain_results();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (pending_prefetch.size() != 0) @(posedge clk);
  endtask

  // Threshold writes happen only with the block idle: drain, then let any
  // request without a prefetch finish its write-back.
  task automatic set_threshold(input logic [CONF_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    conf_threshold = value;
  endtask

  task automatic init_slots();
    for (int s = 0; s < 6; s++) begin
      slot_pc[s]     = {$urandom, $urandom};
      slot_page[s]   = page_t'({$urandom, $urandom});
      slot_stride[s] = pick_stride();
    end
    // slot 1 shares slot 0's table entry so the two keep evicting each other
    slot_pc[1] = {slot_pc[1][PC_W-1:IDX_W], slot_pc[0][IDX_W-1:0]};
    if (slot_pc[1] == slot_pc[0]) slot_pc[1][PC_W-1] = ~slot_pc[1][PC_W-1];
    slot_pc[2] = '0;
  endtask

  // Mostly regular strides with random page offsets; some jumps and stride
  // changes; a tenth pure noise. Optionally park the output or drain midway.
  task automatic run_mix(input int n_items, input int park_at, input int drain_at);
    int                s;
    int                r;
    logic [ADDR_W-1:0] addr;
    logic [PC_W-1:0]   pc;
    for (int k = 0; k < n_items; k++) begin
      if (k == park_at) park_req = 1'b1;
      if (k == drain_at) drain_results();
      r = $urandom_range(99);
      s = $urandom_range(5);
      if (r < 80) begin
        slot_page[s] = slot_page[s] + slot_stride[s];
      end else if (r < 90) begin
        slot_page[s] = page_t'({$urandom, $urandom});
        if ($urandom_range(1)) slot_stride[s] = pick_stride();
      end
      addr = {slot_page[s], PAGE_SHIFT'($urandom)};
      pc   = slot_pc[s];
      if (r >= 90) begin
        addr = {$urandom, $urandom};
        pc   = {$urandom, $urandom};
      end
      issue(addr, pc);
    end
  endtask

  // One PC at a fixed stride, long enough to drive the counter into saturation.
  task automatic run_stream(input int n_items);
    for (int k = 0; k < n_items; k++) begin
      sat_page = sat_page + sat_stride;
      issue({sat_page, PAGE_SHIFT'($urandom)}, sat_pc);
    end
  endtask

  // Output side: random backpressure, plus a long park on request.
  initial begin : pf_sink
    int park_left;
    park_left = 0;
    forever begin
      @(negedge clk);
      if (park_req) begin
        park_req  = 1'b0;
        park_left = PARK_CYCLES;
      end
      if (park_left > 0) begin
        park_left--;
        pf_if.ready = 1'b0;
      end else begin
        pf_if.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check each prefetch taken against the oldest one owed.
  always @(posedge clk) begin
    page_t want;
    if (rst_n && pf_if.valid && pf_if.ready) begin
      if (pending_prefetch.size() == 0) begin
        $display("%0t: unexpected prefetch: expected none, got %h", $time,
                 pf_if.prefetch_page);
        mismatch_count++;
      end else begin
        want = pending_prefetch.pop_front();
        if (pf_if.prefetch_page !== want) begin
          $display("%0t: prefetch_page mismatch: expected %h, got %h", $time, want,
                   pf_if.prefetch_page);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    page_t pf;
    bit    emits;
    int    waited;

    // Drive every input to a known value before the first edge.
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    req_if.valid           = 1'b0;
    req_if.access_address  = '0;
    req_if.program_counter = '0;
    pf_if.ready            = 1'b0;
    send_gap_pct           = 0;
    recv_stall_pct         = 0;
    park_req               = 1'b0;
    mismatch_count         = 0;
    conf_threshold         = THRESHOLD_RESET;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_tag[i]    = '0;
      tbl_last[i]   = '0;
      tbl_stride[i] = '0;
      tbl_conf[i]   = '0;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table under the reset threshold. The first request simply
    // waits out the clearing pass on the ready handshake.
    foreach (dir_rows[n]) begin
      send_access(dir_rows[n].addr, dir_rows[n].pc);
      emits = stride_predict(dir_rows[n].addr, dir_rows[n].pc, pf);
      if (dir_rows[n].has_typed) begin
        if (dir_rows[n].typed_emits) owe_prefetch(dir_rows[n].typed_page);
      end else if (emits) begin
        owe_prefetch(pf);
      end
    end

    // Threshold zero, no idling: every hit that learns or matches its stride emits. Park the output partway so
    // the output register fills and the input stalls behind it.
    set_threshold('0);
    init_slots();
    run_mix(90, 30, -1);

    // Sender mostly idle.
    set_threshold(CONF_W'(1));
    send_gap_pct = 67;
    run_mix(90, -1, -1);

    // Receiver mostly stalling; pause the sender until all prefetches are out.
    set_threshold(CONF_W'(3));
    send_gap_pct   = 0;
    recv_stall_pct = 67;
    init_slots();
    run_mix(90, -1, 45);

    // Both sides idling, random threshold, another park.
    set_threshold(CONF_W'($urandom_range(254)));
    send_gap_pct   = 29;
    recv_stall_pct = 29;
    run_mix(90, 50, -1);

    // Threshold 255: nothing ever emits while one stream saturates its counter.
    set_threshold(CONF_MAX);
    sat_pc     = {$urandom, $urandom};
    sat_page   = page_t'({$urandom, $urandom});
    sat_stride = pick_stride();
    run_stream(262);

    // Threshold 254: the saturated counter now emits on every hit; a jump
    // at the end clears it.
    set_threshold(CONF_MAX - 1'b1);
    send_gap_pct   = 0;
    recv_stall_pct = 67;
    run_stream(30);
    issue({sat_page + sat_stride + page_t'(1), PAGE_SHIFT'($urandom)}, sat_pc);

    // Wind down: collect what is owed, then let the pipeline settle.
    @(negedge clk);
    req_if.valid = 1'b0;
    waited = 0;
    while (pending_prefetch.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_prefetch.size() != 0) begin
      $display("%0t: %0d prefetches never arrived: expected %h, got none", $time,
               pending_prefetch.size(), pending_prefetch[0]);
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
